// ----- hdl/chm_pkg.sv -----
`default_nettype none

package chm_pkg;

  // Cipher geometry.
  localparam int WORD_W      = 32;
  localparam int KEY_WORDS   = 4;
  localparam int RK_COUNT    = 8;
  localparam int RK_IDX_W    = $clog2(RK_COUNT);
  localparam int KEY_IDX_W   = $clog2(KEY_WORDS);
  localparam int CFG_IDX_W   = 8;

  // Number of ARX rounds per block and the width of the round counter.
  localparam int ROUND_COUNT = 80;
  localparam int RND_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = CFG_IDX_W'(KEY_WORDS - 1);

  // Fixed left rotations used by the key schedule and the round.
  function automatic word_t rotl1(input word_t v);
    return {v[WORD_W-2:0], v[WORD_W-1]};
  endfunction

  function automatic word_t rotl8(input word_t v);
    return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
  endfunction

  function automatic word_t rotl11(input word_t v);
    return {v[WORD_W-12:0], v[WORD_W-1:WORD_W-11]};
  endfunction

  // Round key placed at the key word's own slot.
  function automatic word_t rk_low(input word_t k);
    return k ^ rotl1(k) ^ rotl8(k);
  endfunction

  // Round key placed at slot (i + 4) xor 1.
  function automatic word_t rk_high(input word_t k);
    return k ^ rotl1(k) ^ rotl11(k);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cham_128_128_block_encrypt.sv -----
// CHAM-128/128 block encryption, one round per clock.
//
// Key: write key_word_0..key_word_3 through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data). cfg_ready is always high; a
// write updates two of the eight round keys at once, and a write to an index
// past key_word_3 is dropped. Write the key only while the core is idle.
//
// Input: one block of four plaintext words is taken when in_valid and in_ready
// are both high. in_ready is high only while the core holds no block.
// Output: the four ciphertext words are held with out_valid until out_ready.
//
// Rounds: the ARX rounds run one per clock through a single round unit. The
// output register must be emptied before the next block enters, so the core
// takes no new block until the result of the last one is taken. A stalled
// receiver holds the core in its done state with the result unchanged.
//
// Reset clears the sequencer and loads the round keys of the all-zero key.
`default_nettype none

module cham_128_128_block_encrypt (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [chm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire chm_pkg::word_t                   cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire chm_pkg::word_t                   plain_word_0,
  input  wire chm_pkg::word_t                   plain_word_1,
  input  wire chm_pkg::word_t                   plain_word_2,
  input  wire chm_pkg::word_t                   plain_word_3,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output chm_pkg::word_t                        cipher_word_0,
  output chm_pkg::word_t                        cipher_word_1,
  output chm_pkg::word_t                        cipher_word_2,
  output chm_pkg::word_t                        cipher_word_3
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [chm_pkg::RND_W-1:0] RND_LAST =
    chm_pkg::RND_W'(chm_pkg::ROUND_COUNT - 1);

  logic [1:0]                  state;
  logic [chm_pkg::RND_W-1:0]   rnd;
  chm_pkg::word_t              rk [chm_pkg::RK_COUNT];
  chm_pkg::word_t              x0;
  chm_pkg::word_t              x1;
  chm_pkg::word_t              x2;
  chm_pkg::word_t              x3;
  chm_pkg::word_t              t;

  logic                              cfg_write;
  logic [chm_pkg::KEY_IDX_W-1:0]     key_idx;
  logic [chm_pkg::RK_IDX_W-1:0]      hi_slot;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);

  assign cipher_word_0 = x0;
  assign cipher_word_1 = x1;
  assign cipher_word_2 = x2;
  assign cipher_word_3 = x3;

  // Key writes: only the four key word indexes touch the schedule.
  assign cfg_write = cfg_valid && (cfg_index <= chm_pkg::REG_KEY_WORD_3);
  assign key_idx   = cfg_index[chm_pkg::KEY_IDX_W-1:0];
  assign hi_slot   = {1'b1, key_idx[1], ~key_idx[0]};

  // Round key table, kept in step with the key words.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < chm_pkg::RK_COUNT; i++) begin
        rk[i] <= '0;
      end
    end else if (cfg_write) begin
      rk[chm_pkg::RK_IDX_W'(key_idx)] <= chm_pkg::rk_low(cfg_data);
      rk[hi_slot]                     <= chm_pkg::rk_high(cfg_data);
    end
  end

  // Shared round unit.
  chm_round u_round (
    .x0  (x0),
    .x1  (x1),
    .rk  (rk[rnd[chm_pkg::RK_IDX_W-1:0]]),
    .rnd (rnd),
    .t   (t)
  );

  // Sequencer: load, run the rounds, hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
            rnd   <= '0;
          end
        end
        ST_RUN: begin
          if (rnd == RND_LAST) begin
            state <= ST_DONE;
          end
          rnd <= rnd + 1'b1;
        end
        ST_DONE: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // State words: loaded from the input, shifted by one word each round.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      x0 <= plain_word_0;
      x1 <= plain_word_1;
      x2 <= plain_word_2;
      x3 <= plain_word_3;
    end else if (state == ST_RUN) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= t;
    end
  end

  // The core never offers a result while it can take a new block.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // An accepted block starts at round zero.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RUN && rnd == '0))
    else $error("block did not start at round zero");

  // The last round hands the block to the output.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && rnd == RND_LAST) |=> out_valid)
    else $error("result not offered after the last round");

  // A write of key word 0 lands in slots 0 and 5.
  a_key0: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == chm_pkg::REG_KEY_WORD_0) |=>
      (rk[0] == chm_pkg::rk_low($past(cfg_data)) &&
       rk[5] == chm_pkg::rk_high($past(cfg_data))))
    else $error("round keys not updated from key word 0");

endmodule

`default_nettype wire

// ----- hdl/chm_round.sv -----
`default_nettype none

// One CHAM-128 ARX round: produces the new last state word.
module chm_round (
  input  wire chm_pkg::word_t            x0,
  input  wire chm_pkg::word_t            x1,
  input  wire chm_pkg::word_t            rk,
  input  wire logic [chm_pkg::RND_W-1:0] rnd,
  output chm_pkg::word_t                 t
);

  chm_pkg::word_t mix;
  chm_pkg::word_t sum;

  // Odd rounds rotate the second word by 8 and the sum by 1; even rounds swap them.
  always_comb begin
    if (rnd[0]) begin
      mix = chm_pkg::rotl8(x1) ^ rk;
    end else begin
      mix = chm_pkg::rotl1(x1) ^ rk;
    end
    sum = (x0 ^ chm_pkg::WORD_W'(rnd)) + mix;
    if (rnd[0]) begin
      t = chm_pkg::rotl1(sum);
    end else begin
      t = chm_pkg::rotl8(sum);
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  typedef logic [3:0][chm_pkg::WORD_W-1:0] block_t;

  localparam int IDLE_PCT       = 31;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int STREAM_PHASES  = 9;
  localparam int PHASE_BLOCKS   = 148;
  localparam int PAUSE_PHASE    = 4;
  localparam int STEADY_PHASE   = 6;

  // Indexes past the last key register; writes there must be dropped.
  localparam logic [chm_pkg::CFG_IDX_W-1:0] REG_PAST_KEY  = chm_pkg::REG_KEY_WORD_3 + 1'b1;
  localparam logic [chm_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

  logic                          clk;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [chm_pkg::CFG_IDX_W-1:0] cfg_index;
  chm_pkg::word_t                cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  chm_pkg::word_t                plain_word_0;
  chm_pkg::word_t                plain_word_1;
  chm_pkg::word_t                plain_word_2;
  chm_pkg::word_t                plain_word_3;
  logic                          out_valid;
  logic                          out_ready;
  chm_pkg::word_t                cipher_word_0;
  chm_pkg::word_t                cipher_word_1;
  chm_pkg::word_t                cipher_word_2;
  chm_pkg::word_t                cipher_word_3;

  // Testbench copy of the key and its round key schedule.
  chm_pkg::word_t key_copy [chm_pkg::KEY_WORDS];
  chm_pkg::word_t round_keys [chm_pkg::RK_COUNT];
  block_t         expected_blocks [$];
  int             error_count;
  bit             no_idle;
  int             stall_cycles;

  cham_128_128_block_encrypt uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .plain_word_0  (plain_word_0),
    .plain_word_1  (plain_word_1),
    .plain_word_2  (plain_word_2),
    .plain_word_3  (plain_word_3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cipher_word_0 (cipher_word_0),
    .cipher_word_1 (cipher_word_1),
    .cipher_word_2 (cipher_word_2),
    .cipher_word_3 (cipher_word_3)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic chm_pkg::word_t rot_left(input chm_pkg::word_t v, input int unsigned n);
    return (v << n) | (v >> (chm_pkg::WORD_W - n));
  endfunction

  // Each key word yields two round keys: one at its own slot, one at (i + 4) xor 1.
  function automatic void build_round_keys();
    chm_pkg::word_t               k;
    chm_pkg::word_t               base;
    logic [chm_pkg::RK_IDX_W-1:0] slot;
    for (int i = 0; i < chm_pkg::KEY_WORDS; i++) begin
      k = key_copy[i];
      base = k ^ rot_left(k, 1);
      round_keys[i] = base ^ rot_left(k, 8);
      slot = chm_pkg::RK_IDX_W'(i + 4) ^ chm_pkg::RK_IDX_W'(1);
      round_keys[slot] = base ^ rot_left(k, 11);
    end
  endfunction

  // Runs all ARX rounds over one plaintext block.
  function automatic block_t encrypt_block(input block_t plain);
    chm_pkg::word_t x [4];
    chm_pkg::word_t mix;
    chm_pkg::word_t t;
    bit             odd;
    block_t         cipher;
    for (int j = 0; j < 4; j++) x[j] = plain[j];
    for (int r = 0; r < chm_pkg::ROUND_COUNT; r++) begin
      odd = r[0];
      mix = rot_left(x[1], odd ? 8 : 1) ^ round_keys[r % chm_pkg::RK_COUNT];
      t = rot_left((x[0] ^ chm_pkg::word_t'(r)) + mix, odd ? 1 : 8);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    for (int j = 0; j < 4; j++) cipher[j] = x[j];
    return cipher;
  endfunction

  // Plaintext words lean on the extremes now and then.
  function automatic chm_pkg::word_t random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Writes one configuration register and mirrors a key word write in the key copy.
  task automatic write_key_reg(input logic [chm_pkg::CFG_IDX_W-1:0] idx,
                               input chm_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= chm_pkg::REG_KEY_WORD_3) begin
      key_copy[idx[chm_pkg::KEY_IDX_W-1:0]] = data;
      build_round_keys();
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input chm_pkg::word_t k0, input chm_pkg::word_t k1,
                          input chm_pkg::word_t k2, input chm_pkg::word_t k3);
    write_key_reg(chm_pkg::REG_KEY_WORD_0, k0);
    write_key_reg(chm_pkg::REG_KEY_WORD_0 + 1'b1, k1);
    write_key_reg(chm_pkg::REG_KEY_WORD_0 + 2'd2, k2);
    write_key_reg(chm_pkg::REG_KEY_WORD_3, k3);
  endtask

  // Sends one plaintext block after an optional random gap.
  task automatic send_block(input block_t blk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    plain_word_0 <= blk[0];
    plain_word_1 <= blk[1];
    plain_word_2 <= blk[2];
    plain_word_3 <= blk[3];
    do @(posedge clk); while (!in_ready);
    expected_blocks.push_back(encrypt_block(blk));
  endtask

  task automatic send_words(input chm_pkg::word_t w0, input chm_pkg::word_t w1,
                            input chm_pkg::word_t w2, input chm_pkg::word_t w3);
    block_t blk;
    blk = {w3, w2, w1, w0};
    send_block(blk);
  endtask

  // Holds off the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
  endtask

  // The core is idle once its last result is taken; key writes may follow.
  task automatic settle_for_config();
    wait_for_results();
    repeat (2) @(posedge clk);
  endtask

  // The reset schedule is that of the all-zero key.
  task automatic test_reset_key();
    send_words('0, '0, '0, '0);
    send_words('1, '1, '1, '1);
    send_words(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    settle_for_config();
  endtask

  task automatic test_extreme_key();
    load_key('1, '1, '1, '1);
    send_words('0, '0, '0, '0);
    send_words('1, '1, '1, '1);
    send_words(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
    send_words(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_words(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    settle_for_config();
  endtask

  // Key word 2 alone, the other words without it, and writes past the last key register.
  task automatic test_register_index();
    load_key('0, '0, '0, '0);
    write_key_reg(chm_pkg::REG_KEY_WORD_0 + 2'd2, 32'h0f0e_0d0c);
    send_words(32'h3322_1100, 32'h7766_5544, 32'hbbaa_9988, 32'hffee_ddcc);
    settle_for_config();
    write_key_reg(REG_PAST_KEY, '1);
    write_key_reg(REG_TOP_INDEX, '1);
    write_key_reg(chm_pkg::CFG_IDX_W'($urandom_range(chm_pkg::KEY_WORDS + 1, 254)), $urandom);
    send_words(32'h3322_1100, 32'h7766_5544, 32'hbbaa_9988, 32'hffee_ddcc);
    settle_for_config();
    write_key_reg(chm_pkg::REG_KEY_WORD_0, 32'h0302_0100);
    write_key_reg(chm_pkg::REG_KEY_WORD_0 + 1'b1, 32'h0706_0504);
    write_key_reg(chm_pkg::REG_KEY_WORD_3, 32'h0b0a_0908);
    send_words('1, '0, '1, '0);
    send_words(32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
    settle_for_config();
  endtask

  // A new key must apply to the very next block.
  task automatic test_key_change();
    load_key($urandom, $urandom, $urandom, $urandom);
    send_words(32'hdead_beef, 32'h0bad_f00d, 32'hcafe_babe, 32'h1234_5678);
    send_words(32'h1234_5678, 32'hcafe_babe, 32'h0bad_f00d, 32'hdead_beef);
    settle_for_config();
    write_key_reg(chm_pkg::REG_KEY_WORD_0 + 1'b1, $urandom);
    send_words(32'hdead_beef, 32'h0bad_f00d, 32'hcafe_babe, 32'h1234_5678);
    send_words(32'h1234_5678, 32'hcafe_babe, 32'h0bad_f00d, 32'hdead_beef);
    settle_for_config();
  endtask

  // Random blocks over several keys, extremes among them.
  task automatic test_random_stream();
    block_t blk;
    for (int phase = 0; phase < STREAM_PHASES; phase++) begin
      case (phase)
        0: load_key('1, '1, '1, '1);
        1: load_key('0, '0, '0, '0);
        default: load_key($urandom, $urandom, $urandom, $urandom);
      endcase
      if ($urandom_range(0, 1) == 0)
        write_key_reg(chm_pkg::CFG_IDX_W'($urandom_range(chm_pkg::KEY_WORDS, 255)), $urandom);
      no_idle = (phase == STEADY_PHASE);
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (phase == PAUSE_PHASE && n == PHASE_BLOCKS / 2)
          wait_for_results();
        for (int j = 0; j < 4; j++) blk[j] = random_word();
        send_block(blk);
      end
      settle_for_config();
      no_idle = 1'b0;
    end
  endtask

  // Receiver: random stalls except during the steady phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compares each taken result with the oldest expected ciphertext.
  always @(posedge clk) begin : check_result
    block_t got;
    block_t want;
    if (!rst && out_valid && out_ready) begin
      got = {cipher_word_3, cipher_word_2, cipher_word_1, cipher_word_0};
      if (expected_blocks.size() == 0) begin
        report_error($sformatf("unexpected result %h", got));
      end else begin
        want = expected_blocks.pop_front();
        for (int j = 0; j < 4; j++) begin
          if (got[j] !== want[j])
            report_error($sformatf("cipher_word_%0d got %h expected %h", j, got[j], want[j]));
        end
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    plain_word_0 = '0;
    plain_word_1 = '0;
    plain_word_2 = '0;
    plain_word_3 = '0;
    error_count  = 0;
    no_idle      = 1'b0;
    stall_cycles = 0;
    for (int i = 0; i < chm_pkg::KEY_WORDS; i++) key_copy[i] = '0;
    build_round_keys();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_extreme_key();
    test_register_index();
    test_key_change();
    test_random_stream();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/chm_pkg.sv
hdl/chm_round.sv
hdl/cham_128_128_block_encrypt.sv
sim/tb_top.sv
